// File: hdl/phc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_pkg
// Types, tag codes and command codes for the pair heap copying collector.
// ----------------------------------------------------------------------------
package phc_pkg;

   localparam int HEAP_PAIRS_DEF = 1024;

   localparam logic [3:0] TAG_BROKEN = 4'd0;
   localparam logic [3:0] TAG_NIL    = 4'd6;
   localparam logic [3:0] TAG_CONS   = 4'd7;

   localparam logic [2:0] CMD_ALLOC   = 3'd0;
   localparam logic [2:0] CMD_CAR     = 3'd1;
   localparam logic [2:0] CMD_CDR     = 3'd2;
   localparam logic [2:0] CMD_SETROOT = 3'd3;
   localparam logic [2:0] CMD_COLLECT = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] first_object;
      logic [63:0] second_object;
   } req_type;

   typedef struct packed {
      logic [63:0] result_object;
      logic [1:0]  status;
      logic [10:0] pairs_in_use;
   } rsp_type;

   // datapath operations issued by the controller
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;  // capture request, check it
   localparam logic [3:0] OP_ALLOC     = 4'd2;  // write new pair
   localparam logic [3:0] OP_READ      = 4'd3;  // issue field read
   localparam logic [3:0] OP_SETROOT   = 4'd4;
   localparam logic [3:0] OP_GC_START  = 4'd5;  // reset counts, object = root
   localparam logic [3:0] OP_RL_READ   = 4'd6;  // read old pair of object
   localparam logic [3:0] OP_RL_DONE   = 4'd7;  // decide forward or copy
   localparam logic [3:0] OP_RL_STORE  = 4'd8;  // store relocated object
   localparam logic [3:0] OP_SCAN_READ = 4'd9;  // read pair under scan
   localparam logic [3:0] OP_SCAN_CDR  = 4'd10; // object = saved cdr
   localparam logic [3:0] OP_GC_END    = 4'd11; // swap halves
   localparam logic [3:0] OP_RESULT    = 4'd12; // load output register
   localparam logic [3:0] OP_SCAN_LOAD = 4'd13; // object = scanned car, save cdr

   // relocation targets
   localparam logic [1:0] TGT_ROOT = 2'd0;
   localparam logic [1:0] TGT_CAR  = 2'd1;
   localparam logic [1:0] TGT_CDR  = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] target;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       bad;        // request fails checks (status 1)
      logic       full;       // allocate on a full heap
      logic       nil_pass;   // car/cdr of nil
      logic       is_pair;    // object under relocation needs moving
      logic       forwarded;  // old pair already holds a broken heart
      logic       scan_more;  // scan below free count
   } sts_type;

endpackage

// File: hdl/phc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_datapath
// Pair stores, heap counters, root and the output register.
// ----------------------------------------------------------------------------
module phc_datapath
   import phc_pkg::*;
#(
   parameter int HEAP_PAIRS = HEAP_PAIRS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  ctl_type ctl,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(HEAP_PAIRS);
   localparam int CW = $clog2(HEAP_PAIRS + 1);
   localparam int AW = IW + 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(HEAP_PAIRS);

   logic [63:0] car_mem [2*HEAP_PAIRS];
   logic [63:0] cdr_mem [2*HEAP_PAIRS];

   req_type     req_ff;
   logic        half_ff;
   logic [CW-1:0] free_ff, scan_ff, old_cnt_ff;
   logic [63:0] root_ff;
   logic [63:0] obj_ff, obj_in;       // object under relocation
   logic [63:0] rd_car_ff, rd_cdr_ff; // registered memory read data
   logic [63:0] scan_cdr_ff;
   logic        alloc_ok_ff;          // allocate wrote a pair
   logic [63:0] res_in;
   rsp_type     rsp_ff;

   function automatic logic [3:0] tag_of(input logic [63:0] o);
      return o[63:60];
   endfunction

   // pair index valid against a count
   function automatic logic idx_ok(input logic [63:0] o, input logic [CW-1:0] c);
      return (o[59:0] < 60'(c));
   endfunction

   logic a_pair, b_pair, a_ok, b_ok, bad_a, bad_b;
   always_comb begin
      a_pair = tag_of(req_ff.first_object) == TAG_CONS;
      b_pair = tag_of(req_ff.second_object) == TAG_CONS;
      a_ok   = a_pair && idx_ok(req_ff.first_object, free_ff);
      b_ok   = b_pair && idx_ok(req_ff.second_object, free_ff);
      bad_a  = a_pair && !a_ok;
      bad_b  = b_pair && !b_ok;
   end

   // request checks
   always_comb begin
      sts.cmd = req_ff.cmd;
      sts.nil_pass = tag_of(req_ff.first_object) == TAG_NIL;
      sts.full = free_ff >= FULL_CNT;
      case (req_ff.cmd)
         CMD_ALLOC: sts.bad = bad_a || bad_b ||
                              tag_of(req_ff.first_object) == TAG_BROKEN;
         CMD_CAR, CMD_CDR: sts.bad = !sts.nil_pass && !a_ok;
         CMD_SETROOT: sts.bad = bad_a;
         CMD_COLLECT: sts.bad = 1'b0;
         default: sts.bad = 1'b1;
      endcase
      sts.is_pair = tag_of(obj_ff) == TAG_CONS && idx_ok(obj_ff, old_cnt_ff) &&
                    free_ff < FULL_CNT;
      sts.forwarded = tag_of(rd_car_ff) == TAG_BROKEN;
      sts.scan_more = scan_ff < free_ff;
   end

   logic [AW-1:0] cur_base, new_base, old_at, new_at, scan_at, rd_addr, wr_addr;
   logic [63:0]   moved;
   always_comb begin
      cur_base = half_ff ? AW'(HEAP_PAIRS) : '0;
      new_base = half_ff ? '0 : AW'(HEAP_PAIRS);
      old_at   = cur_base + AW'(obj_ff[IW-1:0]);
      new_at   = new_base + AW'(free_ff);
      scan_at  = new_base + AW'(scan_ff);
      moved    = {TAG_CONS, 60'(free_ff)};
      rd_addr  = (ctl.op == OP_SCAN_READ) ? scan_at :
                 (ctl.op == OP_RL_READ) ? old_at :
                 cur_base + AW'(req_ff.first_object[IW-1:0]);
      wr_addr  = scan_at;
   end

   // memories: one read port, writes per operation
   always_ff @(posedge clock) begin
      if (ctl.op == OP_READ || ctl.op == OP_RL_READ || ctl.op == OP_SCAN_READ) begin
         rd_car_ff <= car_mem[rd_addr];
         rd_cdr_ff <= cdr_mem[rd_addr];
      end
      if (ctl.op == OP_ALLOC) begin
         car_mem[cur_base + AW'(free_ff)] <= req_ff.first_object;
         cdr_mem[cur_base + AW'(free_ff)] <= req_ff.second_object;
      end
      if (ctl.op == OP_RL_DONE && sts.is_pair && !sts.forwarded) begin
         car_mem[new_at] <= rd_car_ff;
         cdr_mem[new_at] <= rd_cdr_ff;
         car_mem[old_at] <= {TAG_BROKEN, 60'd0};
         cdr_mem[old_at] <= moved;
      end
      if (ctl.op == OP_RL_STORE && ctl.target == TGT_CAR) car_mem[wr_addr] <= obj_ff;
      if (ctl.op == OP_RL_STORE && ctl.target == TGT_CDR) cdr_mem[wr_addr] <= obj_ff;
   end

   // relocated object update
   always_comb begin
      obj_in = obj_ff;
      case (ctl.op)
         OP_GC_START: obj_in = root_ff;
         OP_SCAN_READ: obj_in = obj_ff;
         OP_SCAN_LOAD: obj_in = rd_car_ff;
         OP_RL_DONE: begin
            if (sts.is_pair) obj_in = sts.forwarded ? rd_cdr_ff : moved;
         end
         OP_SCAN_CDR: obj_in = scan_cdr_ff;
         default: obj_in = obj_ff;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
         free_ff <= '0;
         scan_ff <= '0;
         root_ff <= {TAG_NIL, 60'd0};
      end else begin
         case (ctl.op)
            OP_ALLOC: free_ff <= free_ff + 1'b1;
            OP_SETROOT: root_ff <= req_ff.first_object;
            OP_GC_START: begin
               free_ff <= '0;
               scan_ff <= '0;
            end
            OP_RL_DONE: if (sts.is_pair && !sts.forwarded) free_ff <= free_ff + 1'b1;
            OP_RL_STORE: begin
               if (ctl.target == TGT_ROOT) root_ff <= obj_ff;
               if (ctl.target == TGT_CDR) scan_ff <= scan_ff + 1'b1;
            end
            OP_GC_END: half_ff <= ~half_ff;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      obj_ff <= obj_in;
      if (ctl.op == OP_LOAD) begin
         req_ff <= req;
         alloc_ok_ff <= 1'b0;
      end
      if (ctl.op == OP_ALLOC) alloc_ok_ff <= 1'b1;
      if (ctl.op == OP_GC_START) old_cnt_ff <= free_ff;
      if (ctl.op == OP_SCAN_LOAD) scan_cdr_ff <= rd_cdr_ff;
   end

   // result value
   always_comb begin
      res_in = 64'd0;
      if (!sts.bad) begin
         case (req_ff.cmd)
            CMD_ALLOC: res_in = alloc_ok_ff ? {TAG_CONS, 60'(free_ff - 1'b1)} : 64'd0;
            CMD_CAR: res_in = sts.nil_pass ? req_ff.first_object : rd_car_ff;
            CMD_CDR: res_in = sts.nil_pass ? req_ff.first_object : rd_cdr_ff;
            CMD_SETROOT: res_in = root_ff;
            CMD_COLLECT: res_in = root_ff;
            default: res_in = 64'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_RESULT) begin
         rsp_ff.result_object <= res_in;
         rsp_ff.status <= sts.bad ? ST_BAD :
                          (req_ff.cmd == CMD_ALLOC && !alloc_ok_ff) ? ST_FULL : ST_OK;
         rsp_ff.pairs_in_use <= 11'(free_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hdl/phc_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_control
// Command sequencer for the pair heap, including the collector walk.
// ----------------------------------------------------------------------------
module phc_control
   import phc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_WAITRD  = 4'd2;
   localparam logic [3:0] S_RESULT  = 4'd3;
   localparam logic [3:0] S_RL_READ = 4'd4;
   localparam logic [3:0] S_RL_DONE = 4'd5;
   localparam logic [3:0] S_RL_STORE = 4'd6;
   localparam logic [3:0] S_SCAN    = 4'd7;
   localparam logic [3:0] S_SCAN_WT = 4'd8;
   localparam logic [3:0] S_GC_END  = 4'd9;
   localparam logic [3:0] S_GC_START = 4'd10;
   localparam logic [3:0] S_SCAN_CDR = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] tgt_ff, tgt_in;
   logic       vld_ff, vld_in;
   logic       accept;

   // accept while the output slot is free or draining
   assign req_stall = !(state_ff == S_IDLE && (!vld_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      vld_in   = vld_ff && rsp_stall;
      ctl.op   = OP_NONE;
      ctl.target = tgt_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            ctl.op = OP_LOAD;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.bad) state_in = S_RESULT;
            else case (sts.cmd)
               CMD_ALLOC: begin
                  if (!sts.full) ctl.op = OP_ALLOC;
                  state_in = S_RESULT;
               end
               CMD_CAR, CMD_CDR: begin
                  if (!sts.nil_pass) ctl.op = OP_READ;
                  state_in = S_WAITRD;
               end
               CMD_SETROOT: begin
                  ctl.op = OP_SETROOT;
                  state_in = S_RESULT;
               end
               default: state_in = S_GC_START;
            endcase
         end
         S_WAITRD: state_in = S_RESULT;
         S_GC_START: begin
            ctl.op = OP_GC_START;
            tgt_in = TGT_ROOT;
            state_in = S_RL_READ;
         end
         S_RL_READ: begin
            ctl.op = OP_RL_READ;
            state_in = S_RL_DONE;
         end
         S_RL_DONE: begin
            ctl.op = OP_RL_DONE;
            state_in = S_RL_STORE;
         end
         S_RL_STORE: begin
            ctl.op = OP_RL_STORE;
            case (tgt_ff)
               TGT_CAR: state_in = S_SCAN_CDR;
               default: state_in = S_SCAN;
            endcase
         end
         S_SCAN_CDR: begin
            ctl.op = OP_SCAN_CDR;
            tgt_in = TGT_CDR;
            state_in = S_RL_READ;
         end
         S_SCAN: begin
            if (sts.scan_more) begin
               ctl.op = OP_SCAN_READ;
               state_in = S_SCAN_WT;
            end else state_in = S_GC_END;
         end
         S_SCAN_WT: begin
            // read data holds car and cdr of the scanned pair
            ctl.op = OP_SCAN_LOAD;
            tgt_in = TGT_CAR;
            state_in = S_RL_READ;
         end
         S_GC_END: begin
            ctl.op = OP_GC_END;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            ctl.op = OP_RESULT;
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tgt_ff <= TGT_ROOT;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tgt_ff <= tgt_in;
         vld_ff <= vld_in;
      end
   end

endmodule

// File: hdl/pair_heap_copying_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_heap_copying_collector
// Cons pair heap with a semispace copying collector.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type
//   rsp_      out        rsp_valid/rsp_stall  rsp_type
//
// Car and cdr wait on the registered read port of the pair stores. Collect
// relocates the root, then scans each copied pair and relocates its car and
// cdr through the one read port of the stores. Reset is synchronous and clears
// counters, root and handshake state; the stores are not cleared. A stalled
// result holds while the next request waits at the input.
// ----------------------------------------------------------------------------
module pair_heap_copying_collector
   import phc_pkg::*;
#(
   parameter int HEAP_PAIRS = HEAP_PAIRS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;

   phc_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .ctl(ctl)
   );

   phc_datapath #(.HEAP_PAIRS(HEAP_PAIRS)) u_datapath (
      .clock(clock), .reset(reset),
      .req(req_data), .ctl(ctl), .sts(sts), .rsp_data(rsp_data)
   );

endmodule
